// ===== hdl/cfa_pkg.sv =====
// Shared types, constants and helper functions of the GF(2^255-19) arithmetic unit.
package cfa_pkg;

	localparam int NUM_LIMBS = 16;
	localparam int LIMB_W = 16;
	localparam int IDX_W = 4;
	localparam int OPND_W = 17;
	localparam int ACC_W = 34;
	localparam int NB_W = 24;
	localparam int LOAD_W = 18;
	localparam int CARRY_W = 7;
	localparam int FOLD_256 = 38;
	localparam int FOLD_255 = 19;
	localparam int EXP_TOP_BIT = 253;
	localparam int EXP_ZERO_BIT_LO = 2;
	localparam int EXP_ZERO_BIT_HI = 4;
	localparam logic [LIMB_W-1:0] PRIME_LOW = 16'hffed;
	localparam logic [LIMB_W-1:0] PRIME_MID = 16'hffff;
	localparam logic [LIMB_W-1:0] PRIME_TOP = 16'h7fff;
	localparam logic [IDX_W-1:0] TOP_LIMB = IDX_W'(NUM_LIMBS - 1);

	typedef enum logic [2:0] {
		CMD_LOAD_A = 3'd0,
		CMD_LOAD_B = 3'd1,
		CMD_MUL    = 3'd2,
		CMD_SQR    = 3'd3,
		CMD_ADD    = 3'd4,
		CMD_SUB    = 3'd5,
		CMD_INV    = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		CM_HOLD,
		CM_LOAD,
		CM_MAC,
		CM_CARRY,
		CM_ROT
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t          mode;
		logic [OPND_W-1:0]   y;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		FM_IDLE,
		FM_FOLD,
		FM_TEST,
		FM_EMIT
	} fin_mode_t;

	typedef struct packed {
		fin_mode_t          mode;
		logic [IDX_W-1:0]   pos;
		logic               plus19;
	} fin_ctrl_t;

	function automatic logic [LIMB_W-1:0] prime_limb(input logic [IDX_W-1:0] idx);
		logic [LIMB_W-1:0] r;
		r = PRIME_MID;
		if (idx == '0)
			r = PRIME_LOW;
		else if (idx == TOP_LIMB)
			r = PRIME_TOP;
		return r;
	endfunction

	function automatic logic [NB_W-1:0] times38(input logic [LOAD_W-1:0] v);
		return NB_W'(v) * NB_W'(FOLD_256);
	endfunction

endpackage

// ===== hdl/cfa_cell.sv =====
// One limb cell: multiplicand, multiplier shift tap and wide accumulator limb.
module cfa_cell (
	input  logic                            clk,
	input  cfa_pkg::cell_ctrl_t             ctrl,
	input  logic [cfa_pkg::OPND_W-1:0]      x_in,
	input  logic [cfa_pkg::OPND_W-1:0]      y_in,
	input  logic [cfa_pkg::OPND_W-1:0]      yr_prev,
	input  logic [cfa_pkg::NB_W-1:0]        nb,
	input  logic [cfa_pkg::LOAD_W-1:0]      w_in,
	output logic [cfa_pkg::ACC_W-1:0]       w,
	output logic [cfa_pkg::OPND_W-1:0]      yr
);

	logic [cfa_pkg::OPND_W-1:0] x_q;
	logic [cfa_pkg::OPND_W-1:0] yr_q;
	logic [cfa_pkg::ACC_W-1:0]  w_q;
	logic [cfa_pkg::ACC_W-1:0]  prod;

	assign prod = {17'b0, x_q} * {17'b0, ctrl.y};
	assign w = w_q;
	assign yr = yr_q;

	always_ff @(posedge clk) begin
		case (ctrl.mode)
			cfa_pkg::CM_LOAD: begin
				x_q  <= x_in;
				yr_q <= y_in;
				w_q  <= {16'b0, w_in};
			end
			cfa_pkg::CM_MAC: begin
				w_q  <= prod + {10'b0, nb};
				yr_q <= yr_prev;
			end
			// keep own low half, take the carry from the limb below
			cfa_pkg::CM_CARRY: w_q <= {18'b0, w_q[15:0]} + {10'b0, nb};
			cfa_pkg::CM_ROT:   w_q <= {16'b0, w_in};
			default: ;
		endcase
	end

endmodule

// ===== hdl/cfa_final.sv =====
// Serial carry, fold and final compare unit at the low end of the cell chain.
module cfa_final (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfa_pkg::fin_ctrl_t            ctrl,
	input  logic [cfa_pkg::OPND_W-1:0]    w0,
	output logic [cfa_pkg::LIMB_W-1:0]    rot,
	output logic [cfa_pkg::LIMB_W-1:0]    limb
);

	logic [cfa_pkg::CARRY_W-1:0] carry_q;
	logic [17:0]                 v;
	logic [16:0]                 d;
	logic [cfa_pkg::CARRY_W-1:0] hi19;
	logic                        top;

	assign v = {1'b0, w0} + {11'b0, carry_q};
	assign d = {1'b0, w0[15:0]} - {10'b0, carry_q};
	assign hi19 = {4'b0, v[17:15]} * cfa_pkg::CARRY_W'(cfa_pkg::FOLD_255);
	assign top = (ctrl.pos == cfa_pkg::TOP_LIMB);
	assign rot = top ? {1'b0, v[14:0]} : v[15:0];
	assign limb = d[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			case (ctrl.mode)
				cfa_pkg::FM_IDLE: carry_q <= '0;
				cfa_pkg::FM_FOLD: begin
					// weight 2^255 re-enters limb 0 times 19
					if (top)
						carry_q <= hi19 + (ctrl.plus19 ?
							cfa_pkg::CARRY_W'(cfa_pkg::FOLD_255) : '0);
					else
						carry_q <= {5'b0, v[17:16]};
				end
				cfa_pkg::FM_TEST: begin
					// bit 255 of t+19 set means t >= p; else subtract the 19 again
					if (top)
						carry_q <= v[15] ? '0 : cfa_pkg::CARRY_W'(cfa_pkg::FOLD_255);
					else
						carry_q <= {5'b0, v[17:16]};
				end
				cfa_pkg::FM_EMIT: carry_q <= {6'b0, d[16]};
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/curve25519_field_arithmetic_unit.sv =====
// Multiply, square, add, subtract and invert modulo 2^255-19 on a chain of limb cells.
// Loads leave busy low. The other commands hold busy until their emit pass ends; the 16
// result limbs follow back to back, each registered in the cycle after its emit step.
// Each field multiply is a load, a MAC pass and a carry pass; invert runs 506 of them,
// then the final fold, test and emit reduction.
// Asynchronous reset clears control state and both operands to zero.
module curve25519_field_arithmetic_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  command,
	input  logic [3:0]  limb_index,
	input  logic [15:0] limb_value,
	output logic        busy,
	output logic        result_valid,
	output logic [3:0]  result_index,
	output logic [15:0] result_limb,
	output logic        last_limb
);

	localparam int N = cfa_pkg::NUM_LIMBS;
	localparam logic [3:0] CARRY_LAST = 4'd2;
	localparam logic [1:0] FOLD_LAST = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MLD,
		S_MAC,
		S_CARRY,
		S_FOLD,
		S_TEST,
		S_EMIT
	} state_t;

	state_t        state_q;
	logic [3:0]    cnt_q;
	logic [1:0]    pass_q;
	cfa_pkg::cmd_t op_q;
	logic          first_q;
	logic          sub_q;
	logic [7:0]    bit_q;

	logic [15:0] a_q [N];
	logic [15:0] b_q [N];

	logic [cfa_pkg::ACC_W-1:0]  w [N];
	logic [cfa_pkg::OPND_W-1:0] yr [N];
	logic [cfa_pkg::OPND_W-1:0] yr_prev [N];
	logic [cfa_pkg::OPND_W-1:0] x_in [N];
	logic [cfa_pkg::OPND_W-1:0] y_in [N];
	logic [cfa_pkg::NB_W-1:0]   nb [N];
	logic [cfa_pkg::LOAD_W-1:0] w_in [N];

	cfa_pkg::cell_ctrl_t cctl;
	cfa_pkg::fin_ctrl_t  fctl;
	cfa_pkg::cmd_t       cmd;
	logic                accept;
	logic                inv_last;
	logic                use_w_x;
	logic [15:0]         fin_rot;
	logic [15:0]         fin_limb;
	logic [15:0]         load_val;

	assign cmd = cfa_pkg::cmd_t'(command);
	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign inv_last = (bit_q == 8'd0) && sub_q;
	assign use_w_x = (op_q == cfa_pkg::CMD_INV) && !first_q;
	assign load_val = (limb_index == cfa_pkg::TOP_LIMB) ? {1'b0, limb_value[14:0]} : limb_value;

	// operand store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				a_q[i] <= '0;
				b_q[i] <= '0;
			end
		end else if (accept) begin
			if (cmd == cfa_pkg::CMD_LOAD_A)
				a_q[limb_index] <= load_val;
			else if (cmd == cfa_pkg::CMD_LOAD_B)
				b_q[limb_index] <= load_val;
		end
	end

	always_comb begin
		cctl.y = yr[N-1];
		case (state_q)
			S_IDLE:  cctl.mode = (accept && (cmd == cfa_pkg::CMD_ADD || cmd == cfa_pkg::CMD_SUB)) ?
				cfa_pkg::CM_LOAD : cfa_pkg::CM_HOLD;
			S_MLD:   cctl.mode = cfa_pkg::CM_LOAD;
			S_MAC:   cctl.mode = cfa_pkg::CM_MAC;
			S_CARRY: cctl.mode = cfa_pkg::CM_CARRY;
			S_FOLD, S_TEST, S_EMIT: cctl.mode = cfa_pkg::CM_ROT;
			default: cctl.mode = cfa_pkg::CM_HOLD;
		endcase
	end

	always_comb begin
		fctl.pos = cnt_q;
		fctl.plus19 = (pass_q == FOLD_LAST);
		case (state_q)
			S_FOLD:  fctl.mode = cfa_pkg::FM_FOLD;
			S_TEST:  fctl.mode = cfa_pkg::FM_TEST;
			S_EMIT:  fctl.mode = cfa_pkg::FM_EMIT;
			default: fctl.mode = cfa_pkg::FM_IDLE;
		endcase
	end

	// neighbour sums: MAC shifts up one limb, carry mode moves high halves up;
	// anything past limb 15 wraps to the low limbs times 38
	always_comb begin
		yr_prev[0] = '0;
		for (int i = 1; i < N; i++)
			yr_prev[i] = yr[i-1];
		if (state_q == S_MAC) begin
			nb[0] = cfa_pkg::times38({2'b0, w[N-1][15:0]}) + cfa_pkg::times38(w[N-2][33:16]);
			nb[1] = {8'b0, w[0][15:0]} + cfa_pkg::times38(w[N-1][33:16]);
			for (int i = 2; i < N; i++)
				nb[i] = {8'b0, w[i-1][15:0]} + {6'b0, w[i-2][33:16]};
		end else begin
			nb[0] = cfa_pkg::times38(w[N-1][33:16]);
			for (int i = 1; i < N; i++)
				nb[i] = {6'b0, w[i-1][33:16]};
		end
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			x_in[i] = use_w_x ? w[i][16:0] : {1'b0, a_q[i]};
			case (op_q)
				cfa_pkg::CMD_MUL: y_in[i] = {1'b0, b_q[i]};
				cfa_pkg::CMD_INV: y_in[i] = (first_q || sub_q) ? {1'b0, a_q[i]} : w[i][16:0];
				default:          y_in[i] = {1'b0, a_q[i]};
			endcase
			if (state_q == S_IDLE) begin
				if (cmd == cfa_pkg::CMD_SUB)
					w_in[i] = {2'b0, a_q[i]} + {1'b0, cfa_pkg::prime_limb(4'(i)), 1'b0}
						- {2'b0, b_q[i]};
				else
					w_in[i] = {2'b0, a_q[i]} + {2'b0, b_q[i]};
			end else if (state_q == S_MLD) begin
				w_in[i] = '0;
			end else if (i == N - 1) begin
				w_in[i] = {2'b0, fin_rot};
			end else begin
				w_in[i] = w[(i+1) % N][17:0];
			end
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		cfa_cell u_cell (
			.clk     (clk),
			.ctrl    (cctl),
			.x_in    (x_in[g]),
			.y_in    (y_in[g]),
			.yr_prev (yr_prev[g]),
			.nb      (nb[g]),
			.w_in    (w_in[g]),
			.w       (w[g]),
			.yr      (yr[g])
		);
	end

	cfa_final u_final (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (fctl),
		.w0     (w[0][16:0]),
		.rot    (fin_rot),
		.limb   (fin_limb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			pass_q       <= '0;
			op_q         <= cfa_pkg::CMD_MUL;
			first_q      <= 1'b0;
			sub_q        <= 1'b0;
			bit_q        <= '0;
			result_valid <= 1'b0;
			result_index <= '0;
			result_limb  <= '0;
			last_limb    <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			last_limb    <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= cmd;
						first_q <= 1'b1;
						sub_q   <= 1'b0;
						bit_q   <= 8'(cfa_pkg::EXP_TOP_BIT);
						cnt_q   <= '0;
						case (cmd)
							cfa_pkg::CMD_MUL, cfa_pkg::CMD_SQR, cfa_pkg::CMD_INV:
								state_q <= S_MLD;
							cfa_pkg::CMD_ADD, cfa_pkg::CMD_SUB:
								state_q <= S_CARRY;
							default: ;
						endcase
					end
				end
				S_MLD: begin
					state_q <= S_MAC;
					cnt_q   <= '0;
				end
				S_MAC: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == cfa_pkg::TOP_LIMB)
						state_q <= S_CARRY;
				end
				S_CARRY: begin
					if (cnt_q == CARRY_LAST) begin
						cnt_q <= '0;
						if (op_q == cfa_pkg::CMD_INV && !inv_last) begin
							state_q <= S_MLD;
							first_q <= 1'b0;
							// square, then multiply by A except on the two zero exponent bits
							if (!sub_q && bit_q != 8'(cfa_pkg::EXP_ZERO_BIT_LO) &&
								bit_q != 8'(cfa_pkg::EXP_ZERO_BIT_HI)) begin
								sub_q <= 1'b1;
							end else begin
								sub_q <= 1'b0;
								bit_q <= bit_q - 8'd1;
							end
						end else begin
							state_q <= S_FOLD;
							pass_q  <= '0;
						end
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_FOLD: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == cfa_pkg::TOP_LIMB) begin
						if (pass_q == FOLD_LAST)
							state_q <= S_TEST;
						else
							pass_q <= pass_q + 2'd1;
					end
				end
				S_TEST: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == cfa_pkg::TOP_LIMB)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					result_valid <= 1'b1;
					result_index <= cnt_q;
					result_limb  <= fin_limb;
					last_limb    <= (cnt_q == cfa_pkg::TOP_LIMB);
					cnt_q        <= cnt_q + 4'd1;
					if (cnt_q == cfa_pkg::TOP_LIMB)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/cfa_checker.sv =====
// Port-level checks of the field arithmetic unit, bound to the top level.
module cfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic [2:0]  command,
	input logic        busy,
	input logic        result_valid,
	input logic [3:0]  result_index,
	input logic        last_limb
);

	// a result run is sixteen back-to-back limbs in index order
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_limb |=> result_valid &&
			result_index == 4'($past(result_index) + 4'd1))
		else $error("result run broken");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		last_limb |-> result_valid && result_index == cfa_pkg::TOP_LIMB)
		else $error("last limb misplaced");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_index == 4'd0 |-> $past(busy))
		else $error("result without a running operation");

	// codes above invert are unused
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (command == cfa_pkg::CMD_LOAD_A || command == cfa_pkg::CMD_LOAD_B ||
			command > 3'(cfa_pkg::CMD_INV)) |=> !busy)
		else $error("load or unused command raised busy");

	a_op: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (command == cfa_pkg::CMD_MUL || command == cfa_pkg::CMD_ADD ||
			command == cfa_pkg::CMD_INV) |=> busy)
		else $error("operation did not start");

endmodule

bind curve25519_field_arithmetic_unit cfa_checker u_cfa_checker (.*);
